@@ hw/rtl/plkd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle leapfrog kick/drift package
// Shared constants, register and request codes, and saturating helpers.
// ----------------------------------------------------------------------------
package plkd_pkg;

	// Default number of fraction bits of the fixed-point format.
	localparam int FRACTION_BITS_DEF = 40;

	// Latency of the rounding multiplier in register stages.
	localparam int MUL_LAT = 5;

	// Stream payload widths.
	localparam int IN_DATA_W  = 576;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 576;
	localparam int OUT_USER_W = 1;
	localparam int CFG_ADDR_W = 3;

	localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

	// Configuration register indexes.
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_INDIVIDUAL_STEPS = 3'd0,
		REG_SCALE_FACTOR     = 3'd1,
		REG_HUBBLE_RATE      = 3'd2,
		REG_HALF_STEP_DT     = 3'd3,
		REG_CURRENT_TIME     = 3'd4,
		REG_DOMAIN_LENGTH    = 3'd5,
		REG_TIME_TOLERANCE   = 3'd6
	} cfg_reg_t;

	// Request kinds.
	typedef enum logic [1:0] {
		REQ_KICK_FIRST  = 2'd0,
		REQ_KICK_SECOND = 2'd1,
		REQ_DRIFT       = 2'd2
	} req_t;

	// Saturating two's complement add of two 64-bit words.
	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? S64_MIN : S64_MAX;
		end
		return s[63:0];
	endfunction

	// Saturating two's complement subtract of two 64-bit words.
	function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? S64_MIN : S64_MAX;
		end
		return s[63:0];
	endfunction

	// Saturating sum of three words, left to right.
	function automatic logic [63:0] sat_add3(input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] c);
		return sat_add(sat_add(a, b), c);
	endfunction

endpackage

@@ hw/rtl/particle_leapfrog_kick_drift_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle leapfrog kick/drift engine
// Applies half kicks with Hubble drag, keeps energy work totals, and drifts
// positions into a periodic box, one particle record per clock.
// ----------------------------------------------------------------------------
// The block takes one particle record per clock and returns one result per
// record, in order. Its depth is set by the longer of two pipelined chains:
// the kick chain (drag divider of FRACTION_BITS + 1 steps followed by four
// multiplier stages) and the drift chain (box modulo divider of
// 128 - FRACTION_BITS steps). When the result side stalls, the whole
// pipeline holds. Configuration writes are taken at any time but must only
// be issued while the pipeline is empty.
module particle_leapfrog_kick_drift_top #(
	parameter int FRACTION_BITS = plkd_pkg::FRACTION_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write channel.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [plkd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [63:0]                        cfg_data,
	// Particle records in.
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// mass, vel_x, vel_y, vel_z, vec_x, vec_y, vec_z, step_dt, time_mark, active
	input  logic [plkd_pkg::IN_DATA_W-1:0]     s_tdata,
	// req_type
	input  logic [plkd_pkg::IN_USER_W-1:0]     s_tuser,
	input  logic                               s_tlast,
	// Results out.
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// new_vel_x, new_vel_y, new_vel_z, new_pos_x, new_pos_y, new_pos_z,
	// new_time_mark, grav_work_sum, drag_work_sum
	output logic [plkd_pkg::OUT_DATA_W-1:0]    m_tdata,
	// applied
	output logic [plkd_pkg::OUT_USER_W-1:0]    m_tuser,
	output logic                               m_tlast
);

	localparam int F     = FRACTION_BITS;
	localparam int ML    = plkd_pkg::MUL_LAT;
	localparam int NW    = 129 - F;                          // signed drifted position
	localparam int NM_W  = NW - 1;                           // its magnitude
	localparam int DN_W  = (2 * F + 2 > 64) ? 2 * F + 2 : 64; // drag numerator
	localparam int QD    = F + 1;                            // drag quotient bits

	// Stage indexes where results land.
	localparam int K_DER = 1;
	localparam int K_A   = K_DER + ML + 1;
	localparam int K_B   = K_A + 1;
	localparam int K_C   = K_A + ML + 1;
	localparam int K_D   = K_C + ML + 1;
	localparam int K_Q   = K_B + QD + 1;
	localparam int K_DR  = K_Q + ML + 1;
	localparam int K_NV  = K_DR + ML + 1;
	localparam int K_KN  = K_NV + ML + 1;
	localparam int K_KE  = K_KN + ML + 1;
	localparam int K_R   = K_B + NM_W + 1;
	localparam int LAST  = ((K_KE > K_R) ? K_KE : K_R) + 1;

	localparam logic [63:0]     ONE    = 64'd1 << F;
	localparam logic [DN_W-1:0] NUM_HI = DN_W'(1) << (2 * F);

	typedef struct packed {
		logic [1:0]              req;
		logic [62:0]             mass;
		logic [2:0][63:0]        v;
		logic [2:0][63:0]        x;
		logic [62:0]             sd;
		logic [63:0]             tm;
		logic                    active;
		logic                    last;
		logic [63:0]             dt;
		logic                    kick;
		logic                    drift;
		logic [2:0][63:0]        vg;
		logic [63:0]             d;
		logic [63:0]             kv;
		logic [2:0][NW-1:0]      n;
		logic [2:0][NM_W-1:0]    nmag;
		logic [2:0]              nneg;
		logic [2:0][63:0]        nsat;
		logic [DN_W-1:0]         num_d;
		logic [63:0]             kvg;
		logic [63:0]             kev;
		logic [63:0]             kevg;
		logic [QD-1:0]           q;
		logic [63:0]             drag;
		logic [2:0][63:0]        nv;
		logic [63:0]             knv;
		logic [63:0]             gd;
		logic [63:0]             dd;
		logic [2:0][63:0]        np;
		logic                    applied;
		logic [63:0]             gsum;
		logic [63:0]             dsum;
	} pay_t;

	// Configuration registers.
	logic        ind_q;
	logic [62:0] scale_q;
	logic [63:0] hub_q;
	logic [62:0] half_q;
	logic [63:0] cur_q;
	logic [62:0] len_q;
	logic [15:0] tol_q;

	// Work totals.
	logic [63:0] tg_q, td_q;

	pay_t        pipe_s [0:LAST];
	pay_t        nxt    [0:LAST];
	logic [LAST:0] vld_s;
	logic        en;

	// Multiplier and divider results.
	logic [63:0]  g_sat [3];
	logic [63:0]  sv_sat [3];
	logic [127:0] dm_mag [3];
	logic         dm_neg [3];
	logic [63:0]  sg_sat [3];
	logic [63:0]  nv_sat [3];
	logic [63:0]  sn_sat [3];
	logic [62:0]  r_rem [3];
	logic [63:0]  h_sat, kev_sat, kevg_sat, qq_sat, ken_sat;
	logic [QD-1:0] qd_quo;

	// Window test and drift interval on the input stage.
	logic [66:0] win_diff;
	logic [66:0] tol_ext;
	logic        win_hit;
	logic        go;
	logic [64:0] dt_full;
	logic        drag_en;

	// The whole pipeline advances unless the result register is held.
	assign en       = !vld_s[LAST] || m_tready;
	assign s_tready = en;
	assign cfg_ready = 1'b1;
	assign drag_en  = !hub_q[63] && (hub_q != '0) && (scale_q != '0);

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ind_q   <= 1'b0;
			scale_q <= ONE[62:0];
			hub_q   <= '0;
			half_q  <= '0;
			cur_q   <= '0;
			len_q   <= ONE[62:0];
			tol_q   <= 16'd110;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_addr)
				plkd_pkg::REG_INDIVIDUAL_STEPS: ind_q   <= cfg_data[0];
				plkd_pkg::REG_SCALE_FACTOR:     scale_q <= cfg_data[62:0];
				plkd_pkg::REG_HUBBLE_RATE:      hub_q   <= cfg_data;
				plkd_pkg::REG_HALF_STEP_DT:     half_q  <= cfg_data[62:0];
				plkd_pkg::REG_CURRENT_TIME:     cur_q   <= cfg_data;
				plkd_pkg::REG_DOMAIN_LENGTH:    len_q   <= cfg_data[62:0];
				plkd_pkg::REG_TIME_TOLERANCE:   tol_q   <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Time window of a kick: |mismatch| < tolerance, never for zero tolerance.
	always_comb begin
		win_diff = {{3{cur_q[63]}}, cur_q} - {{3{pipe_s[0].tm[63]}}, pipe_s[0].tm};
		if (pipe_s[0].req == plkd_pkg::REQ_KICK_FIRST) begin
			win_diff = win_diff - {3'd0, half_q, 1'b0} + {4'd0, pipe_s[0].sd};
		end
		tol_ext = {51'd0, tol_q};
		win_hit = ($signed(win_diff) < $signed(tol_ext))
			&& ($signed(win_diff) > -$signed(tol_ext));
		go      = ind_q ? win_hit : pipe_s[0].active;
		dt_full = {cur_q[63], cur_q} - {pipe_s[0].tm[63], pipe_s[0].tm};
	end

	// Next value of every stage: carry forward, then fill in what lands there.
	always_comb begin
		nxt[0]        = '0;
		nxt[0].req    = s_tuser[1:0];
		nxt[0].mass   = s_tdata[62:0];
		nxt[0].v[0]   = s_tdata[126:63];
		nxt[0].v[1]   = s_tdata[190:127];
		nxt[0].v[2]   = s_tdata[254:191];
		nxt[0].x[0]   = s_tdata[318:255];
		nxt[0].x[1]   = s_tdata[382:319];
		nxt[0].x[2]   = s_tdata[446:383];
		nxt[0].sd     = s_tdata[509:447];
		nxt[0].tm     = s_tdata[573:510];
		nxt[0].active = s_tdata[574];
		nxt[0].last   = s_tlast;
		for (int k = 1; k <= LAST; k++) begin
			nxt[k] = pipe_s[k-1];
		end

		// Request decode and gating.
		nxt[K_DER].dt    = dt_full[63:0];
		nxt[K_DER].kick  = ((pipe_s[0].req == plkd_pkg::REQ_KICK_FIRST)
			|| (pipe_s[0].req == plkd_pkg::REQ_KICK_SECOND)) && go;
		nxt[K_DER].drift = (pipe_s[0].req == plkd_pkg::REQ_DRIFT)
			&& !dt_full[64] && (dt_full != '0);

		// Gravity kick, drag denominator, old kinetic sum, raw drifted position.
		nxt[K_A].d  = plkd_pkg::sat_add(ONE, h_sat);
		nxt[K_A].kv = plkd_pkg::sat_add3(sv_sat[0], sv_sat[1], sv_sat[2]);
		for (int i = 0; i < 3; i++) begin
			nxt[K_A].vg[i] = plkd_pkg::sat_add(pipe_s[K_A-1].v[i], g_sat[i]);
			nxt[K_A].n[i]  = {{(NW-64){pipe_s[K_A-1].x[i][63]}}, pipe_s[K_A-1].x[i]}
				+ (dm_neg[i] ? (~{1'b0, dm_mag[i][NW-2:0]} + NW'(1))
				: {1'b0, dm_mag[i][NW-2:0]});
		end

		// Drag numerator, position magnitude and saturated position.
		nxt[K_B].num_d = NUM_HI + DN_W'(pipe_s[K_B-1].d[63:1]);
		for (int i = 0; i < 3; i++) begin
			nxt[K_B].nneg[i] = pipe_s[K_B-1].n[i][NW-1];
			nxt[K_B].nmag[i] = pipe_s[K_B-1].n[i][NW-1]
				? NM_W'(~pipe_s[K_B-1].n[i] + NW'(1)) : pipe_s[K_B-1].n[i][NM_W-1:0];
			if ((&pipe_s[K_B-1].n[i][NW-1:63]) || !(|pipe_s[K_B-1].n[i][NW-1:63])) begin
				nxt[K_B].nsat[i] = pipe_s[K_B-1].n[i][63:0];
			end else begin
				nxt[K_B].nsat[i] = pipe_s[K_B-1].n[i][NW-1] ? plkd_pkg::S64_MIN
					: plkd_pkg::S64_MAX;
			end
		end

		// Kinetic sum after gravity, and energy before the kick.
		nxt[K_C].kvg = plkd_pkg::sat_add3(sg_sat[0], sg_sat[1], sg_sat[2]);
		nxt[K_C].kev = kev_sat;

		// Energy after gravity.
		nxt[K_D].kevg = kevg_sat;

		// Drag quotient and squared drag factor.
		nxt[K_Q].q     = qd_quo;
		nxt[K_DR].drag = drag_en ? qq_sat : ONE;

		// Dragged velocity and its kinetic sum.
		for (int i = 0; i < 3; i++) begin
			nxt[K_NV].nv[i] = nv_sat[i];
		end
		nxt[K_KN].knv = plkd_pkg::sat_add3(sn_sat[0], sn_sat[1], sn_sat[2]);

		// Work of this kick.
		nxt[K_KE].gd = plkd_pkg::sat_sub(pipe_s[K_KE-1].kevg, pipe_s[K_KE-1].kev);
		nxt[K_KE].dd = plkd_pkg::sat_sub(pipe_s[K_KE-1].kevg, ken_sat);

		// Floor modulo into the box; a zero box length leaves the position saturated.
		for (int i = 0; i < 3; i++) begin
			if (len_q == '0) begin
				nxt[K_R].np[i] = pipe_s[K_R-1].nsat[i];
			end else if (pipe_s[K_R-1].nneg[i] && (r_rem[i] != '0)) begin
				nxt[K_R].np[i] = {1'b0, len_q - r_rem[i]};
			end else begin
				nxt[K_R].np[i] = {1'b0, r_rem[i]};
			end
		end

		// Result register: choose the fields and add the work to the totals.
		nxt[LAST].applied = pipe_s[LAST-1].kick || pipe_s[LAST-1].drift;
		if (pipe_s[LAST-1].kick) begin
			nxt[LAST].v    = pipe_s[LAST-1].nv;
			nxt[LAST].gsum = plkd_pkg::sat_add(tg_q, pipe_s[LAST-1].gd);
			nxt[LAST].dsum = plkd_pkg::sat_add(td_q, pipe_s[LAST-1].dd);
		end else begin
			nxt[LAST].gsum = tg_q;
			nxt[LAST].dsum = td_q;
		end
		if (pipe_s[LAST-1].drift) begin
			nxt[LAST].x  = pipe_s[LAST-1].np;
			nxt[LAST].tm = cur_q;
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k <= LAST; k++) begin
				pipe_s[k] <= nxt[k];
			end
		end
	end

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAST-1:0], s_tvalid};
		end
	end

	// Running work totals, updated as a kicked record enters the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tg_q <= '0;
			td_q <= '0;
		end else if (en && vld_s[LAST-1] && pipe_s[LAST-1].kick) begin
			tg_q <= nxt[LAST].gsum;
			td_q <= nxt[LAST].dsum;
		end
	end

	// Multipliers fed from the decode stage and later stages, and the box modulo dividers.
	plkd_mul #(.SHIFT(F + 1)) u_mul_h (
		.clk(clk), .en(en),
		.a({hub_q[63], hub_q}), .b({2'b00, pipe_s[K_DER].sd}),
		.p_sat(h_sat), .p_mag(), .p_neg()
	);

	for (genvar i = 0; i < 3; i++) begin : g_axis
		plkd_mul #(.SHIFT(F + 1)) u_mul_g (
			.clk(clk), .en(en),
			.a({pipe_s[K_DER].x[i][63], pipe_s[K_DER].x[i]}),
			.b({2'b00, pipe_s[K_DER].sd}),
			.p_sat(g_sat[i]), .p_mag(), .p_neg()
		);
		plkd_mul #(.SHIFT(F)) u_mul_sv (
			.clk(clk), .en(en),
			.a({pipe_s[K_DER].v[i][63], pipe_s[K_DER].v[i]}),
			.b({pipe_s[K_DER].v[i][63], pipe_s[K_DER].v[i]}),
			.p_sat(sv_sat[i]), .p_mag(), .p_neg()
		);
		plkd_mul #(.SHIFT(F)) u_mul_dm (
			.clk(clk), .en(en),
			.a({pipe_s[K_DER].v[i][63], pipe_s[K_DER].v[i]}),
			.b({1'b0, pipe_s[K_DER].dt}),
			.p_sat(), .p_mag(dm_mag[i]), .p_neg(dm_neg[i])
		);
		plkd_mul #(.SHIFT(F)) u_mul_sg (
			.clk(clk), .en(en),
			.a({pipe_s[K_A].vg[i][63], pipe_s[K_A].vg[i]}),
			.b({pipe_s[K_A].vg[i][63], pipe_s[K_A].vg[i]}),
			.p_sat(sg_sat[i]), .p_mag(), .p_neg()
		);
		plkd_mul #(.SHIFT(F)) u_mul_nv (
			.clk(clk), .en(en),
			.a({pipe_s[K_DR].vg[i][63], pipe_s[K_DR].vg[i]}),
			.b({pipe_s[K_DR].drag[63], pipe_s[K_DR].drag}),
			.p_sat(nv_sat[i]), .p_mag(), .p_neg()
		);
		plkd_mul #(.SHIFT(F)) u_mul_sn (
			.clk(clk), .en(en),
			.a({pipe_s[K_NV].nv[i][63], pipe_s[K_NV].nv[i]}),
			.b({pipe_s[K_NV].nv[i][63], pipe_s[K_NV].nv[i]}),
			.p_sat(sn_sat[i]), .p_mag(), .p_neg()
		);
		plkd_div #(.NUM_W(NM_W), .QBITS(NM_W)) u_div_mod (
			.clk(clk), .en(en),
			.num(pipe_s[K_B].nmag[i]), .den(len_q),
			.quo(), .rem(r_rem[i])
		);
	end

	// Kinetic energies from the kinetic sums.
	plkd_mul #(.SHIFT(F + 1)) u_mul_kev (
		.clk(clk), .en(en),
		.a({2'b00, pipe_s[K_A].mass}), .b({pipe_s[K_A].kv[63], pipe_s[K_A].kv}),
		.p_sat(kev_sat), .p_mag(), .p_neg()
	);
	plkd_mul #(.SHIFT(F + 1)) u_mul_kevg (
		.clk(clk), .en(en),
		.a({2'b00, pipe_s[K_C].mass}), .b({pipe_s[K_C].kvg[63], pipe_s[K_C].kvg}),
		.p_sat(kevg_sat), .p_mag(), .p_neg()
	);
	plkd_mul #(.SHIFT(F + 1)) u_mul_ken (
		.clk(clk), .en(en),
		.a({2'b00, pipe_s[K_KN].mass}), .b({pipe_s[K_KN].knv[63], pipe_s[K_KN].knv}),
		.p_sat(ken_sat), .p_mag(), .p_neg()
	);

	// Drag factor: reciprocal of the denominator, then squared.
	plkd_div #(.NUM_W(DN_W), .QBITS(QD)) u_div_drag (
		.clk(clk), .en(en),
		.num(pipe_s[K_B].num_d), .den(pipe_s[K_B].d[62:0]),
		.quo(qd_quo), .rem()
	);
	plkd_mul #(.SHIFT(F)) u_mul_qq (
		.clk(clk), .en(en),
		.a(65'(pipe_s[K_Q].q)), .b(65'(pipe_s[K_Q].q)),
		.p_sat(qq_sat), .p_mag(), .p_neg()
	);

	// Result channel.
	assign m_tvalid = vld_s[LAST];
	assign m_tdata  = {pipe_s[LAST].dsum, pipe_s[LAST].gsum, pipe_s[LAST].tm,
		pipe_s[LAST].x[2], pipe_s[LAST].x[1], pipe_s[LAST].x[0],
		pipe_s[LAST].v[2], pipe_s[LAST].v[1], pipe_s[LAST].v[0]};
	assign m_tuser  = pipe_s[LAST].applied;
	assign m_tlast  = pipe_s[LAST].last;

`ifndef SYNTHESIS
	// A held pipeline keeps every record in place.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("pipeline valid bits moved during a stall");

	// Totals move only when a kicked record enters the result register.
	a_totals_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!(en && vld_s[LAST-1] && pipe_s[LAST-1].kick) |=> ($stable(tg_q) && $stable(td_q)))
		else $error("work totals changed without a kick");

	// A record is never both kicked and drifted.
	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[LAST] |-> !(pipe_s[LAST].kick && pipe_s[LAST].drift))
		else $error("record marked as kick and drift");
`endif

endmodule

@@ hw/rtl/plkd_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rounding fixed-point multiplier
// Five-stage signed multiply built from 32x32 partial products. The product
// is shifted right with rounding half away from zero and given both exact
// (sign and magnitude) and saturated to 64-bit signed.
// ----------------------------------------------------------------------------
module plkd_mul #(
	parameter int SHIFT = 40
) (
	input  logic         clk,
	input  logic         en,
	input  logic [64:0]  a,      // signed, magnitude below 2^64
	input  logic [64:0]  b,      // signed, magnitude below 2^64
	output logic [63:0]  p_sat,
	output logic [127:0] p_mag,
	output logic         p_neg
);

	localparam logic [127:0] RND = 128'd1 << (SHIFT - 1);

	logic [63:0]  am_s1, bm_s1;
	logic         neg_s1;
	logic [63:0]  p00_s2, p01_s2, p10_s2, p11_s2;
	logic         neg_s2;
	logic [127:0] sum_s3;
	logic         neg_s3;
	logic [127:0] mag_s4;
	logic         neg_s4;
	logic [127:0] mag_s5;
	logic         neg_s5;
	logic [63:0]  sat_s5;
	logic         ovf_pos, ovf_neg;

	// Overflow checks on the rounded magnitude.
	assign ovf_pos = mag_s4[127:63] != '0;
	assign ovf_neg = (mag_s4[127:64] != '0) || (mag_s4[63] && (mag_s4[62:0] != '0));

	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 1: magnitudes and product sign.
			am_s1  <= a[64] ? 64'(~a + 65'd1) : a[63:0];
			bm_s1  <= b[64] ? 64'(~b + 65'd1) : b[63:0];
			neg_s1 <= a[64] ^ b[64];
			// Stage 2: partial products.
			p00_s2 <= am_s1[31:0]  * bm_s1[31:0];
			p01_s2 <= am_s1[31:0]  * bm_s1[63:32];
			p10_s2 <= am_s1[63:32] * bm_s1[31:0];
			p11_s2 <= am_s1[63:32] * bm_s1[63:32];
			neg_s2 <= neg_s1;
			// Stage 3: full product.
			sum_s3 <= {64'd0, p00_s2} + {32'd0, p01_s2, 32'd0} + {32'd0, p10_s2, 32'd0}
				+ {p11_s2, 64'd0};
			neg_s3 <= neg_s2;
			// Stage 4: round and shift.
			mag_s4 <= (sum_s3 + RND) >> SHIFT;
			neg_s4 <= neg_s3;
			// Stage 5: apply sign with saturation.
			mag_s5 <= mag_s4;
			neg_s5 <= neg_s4;
			if (neg_s4) begin
				sat_s5 <= ovf_neg ? plkd_pkg::S64_MIN : (~mag_s4[63:0] + 64'd1);
			end else begin
				sat_s5 <= ovf_pos ? plkd_pkg::S64_MAX : mag_s4[63:0];
			end
		end
	end

	assign p_sat = sat_s5;
	assign p_mag = mag_s5;
	assign p_neg = neg_s5;

endmodule

@@ hw/rtl/plkd_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, QBITS stages. The numerator bits above QBITS
// must form a value below the denominator.
// ----------------------------------------------------------------------------
module plkd_div #(
	parameter int NUM_W = 64,
	parameter int QBITS = 41
) (
	input  logic              clk,
	input  logic              en,
	input  logic [NUM_W-1:0]  num,
	input  logic [62:0]       den,
	output logic [QBITS-1:0]  quo,
	output logic [62:0]       rem
);

	logic [62:0]      rem_s [QBITS];
	logic [QBITS-1:0] num_s [QBITS];
	logic [62:0]      den_s [QBITS];
	logic [QBITS-1:0] quo_s [QBITS];

	logic [62:0]      rem_in [QBITS];
	logic [QBITS-1:0] num_in [QBITS];
	logic [62:0]      den_in [QBITS];
	logic [QBITS-1:0] quo_in [QBITS];

	for (genvar j = 0; j < QBITS; j++) begin : g_stage
		logic [63:0] trial;
		logic        ge;

		// Stage inputs come from the ports or from the previous stage.
		if (j == 0) begin : g_first
			assign rem_in[j] = 63'(num >> QBITS);
			assign num_in[j] = num[QBITS-1:0];
			assign den_in[j] = den;
			assign quo_in[j] = '0;
		end else begin : g_next
			assign rem_in[j] = rem_s[j-1];
			assign num_in[j] = num_s[j-1];
			assign den_in[j] = den_s[j-1];
			assign quo_in[j] = quo_s[j-1];
		end

		// Shift in the next numerator bit and try to subtract.
		assign trial = {rem_in[j], num_in[j][QBITS-1-j]};
		assign ge    = trial >= {1'b0, den_in[j]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= ge ? 63'(trial - {1'b0, den_in[j]}) : trial[62:0];
				num_s[j] <= num_in[j];
				den_s[j] <= den_in[j];
				quo_s[j] <= {quo_in[j][QBITS-2:0], ge};
			end
		end
	end

	assign quo = quo_s[QBITS-1];
	assign rem = rem_s[QBITS-1];

endmodule

@@ bench/tb_particle_leapfrog_kick_drift_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle leapfrog kick/drift engine testbench
// Streams particle records through the engine under several register settings
// and random stalls on both sides. Every result is compared, field by field,
// with an in-order prediction of the kick, drift and energy work totals.
// ----------------------------------------------------------------------------
module tb_particle_leapfrog_kick_drift_top;

	localparam int FB = plkd_pkg::FRACTION_BITS_DEF;
	localparam logic [1:0] REQ_NOP = 2'd3;
	localparam logic [63:0] Q_ONE = 64'd1 << FB;

	typedef logic signed [255:0] wide_t;
	localparam wide_t W_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam wide_t W_MIN = -W_MAX - 1;

	// One particle record as it enters the engine.
	typedef struct packed {
		logic [1:0]       req;
		logic [62:0]      mass;
		logic [2:0][63:0] vel;
		logic [2:0][63:0] vec;
		logic [62:0]      sd;
		logic [63:0]      tm;
		logic             active;
		logic             last;
	} rec_t;

	// One result: vel xyz, pos xyz, time mark, gravity total, drag total.
	typedef struct packed {
		logic [8:0][63:0] w;
		logic             applied;
		logic             pass_end;
	} res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [plkd_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [63:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [plkd_pkg::IN_DATA_W-1:0] s_tdata = '0;
	logic [plkd_pkg::IN_USER_W-1:0] s_tuser = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [plkd_pkg::OUT_DATA_W-1:0] m_tdata;
	logic [plkd_pkg::OUT_USER_W-1:0] m_tuser;
	logic m_tlast;

	// Register copies and work totals of the predictor.
	logic               m_indiv;
	logic [62:0]        m_scale;
	logic signed [63:0] m_hubble;
	logic [62:0]        m_half;
	logic signed [63:0] m_ctime;
	logic [62:0]        m_len;
	logic [15:0]        m_tol;
	logic signed [63:0] grav_total;
	logic signed [63:0] drag_total;

	rec_t pending_recs[$];
	res_t expected_results[$];
	int   errors = 0;
	int   recs_sent = 0;
	bit   idle_en = 1'b1;
	int   hold_left = 0;
	bit   hold_done = 1'b0;

	string field_name[9] = '{"new_vel_x", "new_vel_y", "new_vel_z", "new_pos_x", "new_pos_y",
		"new_pos_z", "new_time_mark", "grav_work_sum", "drag_work_sum"};

	particle_leapfrog_kick_drift_top DUT (.*);

	always #6 clk = ~clk;

	initial begin
		#(12 * 500000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Saturate a wide value to 64-bit signed.
	function automatic logic [63:0] clamp64(wide_t v);
		if (v > W_MAX) return plkd_pkg::S64_MAX;
		if (v < W_MIN) return plkd_pkg::S64_MIN;
		return v[63:0];
	endfunction

	function automatic logic [63:0] s_add(logic signed [63:0] a, logic signed [63:0] b);
		wide_t wa, wb;
		wa = a;
		wb = b;
		return clamp64(wa + wb);
	endfunction

	function automatic logic [63:0] s_sub(logic signed [63:0] a, logic signed [63:0] b);
		wide_t wa, wb;
		wa = a;
		wb = b;
		return clamp64(wa - wb);
	endfunction

	// Product shifted right by s, rounded half away from zero, saturated.
	function automatic logic [63:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b, int s);
		wide_t wa, wb, p, unit;
		bit neg;
		wa = a;
		wb = b;
		unit = 1;
		neg = (wa < 0) != (wb < 0);
		if (wa < 0) wa = -wa;
		if (wb < 0) wb = -wb;
		p = ((wa * wb) + (unit <<< (s - 1))) >>> s;
		if (neg) p = -p;
		return clamp64(p);
	endfunction

	// Kinetic energy of a velocity vector times mass.
	function automatic logic [63:0] kin_energy(logic [62:0] mass, logic [2:0][63:0] v);
		logic [63:0] sq;
		sq = s_add(s_add(fx_mul(v[0], v[0], FB), fx_mul(v[1], v[1], FB)),
			fx_mul(v[2], v[2], FB));
		return fx_mul({1'b0, mass}, sq, FB + 1);
	endfunction

	// Expected result for one accepted record; updates the work totals.
	function automatic res_t predict_record(rec_t r);
		res_t res;
		wide_t dw, wt, num, den, quo, p, n, rem, unit;
		logic [63:0] dragf, d, kg;
		logic [2:0][63:0] vg, nv;
		bit gate;
		unit = 1;
		res.w[0] = r.vel[0];
		res.w[1] = r.vel[1];
		res.w[2] = r.vel[2];
		res.w[3] = r.vec[0];
		res.w[4] = r.vec[1];
		res.w[5] = r.vec[2];
		res.w[6] = r.tm;
		res.applied = 1'b0;
		res.pass_end = r.last;
		dw = m_ctime;
		dw = dw - $signed(r.tm);
		if (r.req == plkd_pkg::REQ_KICK_FIRST || r.req == plkd_pkg::REQ_KICK_SECOND) begin
			if (m_indiv) begin
				if (r.req == plkd_pkg::REQ_KICK_FIRST) begin
					wt = {1'b0, m_half};
					dw = dw - (wt <<< 1);
					wt = {1'b0, r.sd};
					dw = dw + wt;
				end
				wt = {1'b0, m_tol};
				gate = (m_tol != 0) && (dw < wt) && (dw > -wt);
			end else begin
				gate = r.active;
			end
			if (gate) begin
				dragf = Q_ONE;
				if (m_hubble > 0 && m_scale != 0) begin
					d = s_add(Q_ONE, fx_mul(m_hubble, {1'b0, r.sd}, FB + 1));
					den = $signed(d);
					num = (unit <<< (2 * FB)) + den / 2;
					quo = num / den;
					dragf = fx_mul(quo[63:0], quo[63:0], FB);
				end
				for (int i = 0; i < 3; i++) begin
					vg[i] = s_add(r.vel[i], fx_mul(r.vec[i], {1'b0, r.sd}, FB + 1));
					nv[i] = fx_mul(vg[i], dragf, FB);
					res.w[i] = nv[i];
				end
				kg = kin_energy(r.mass, vg);
				grav_total = s_add(grav_total, s_sub(kg, kin_energy(r.mass, r.vel)));
				drag_total = s_add(drag_total, s_sub(kg, kin_energy(r.mass, nv)));
				res.applied = 1'b1;
			end
		end else if (r.req == plkd_pkg::REQ_DRIFT && dw > 0) begin
			for (int i = 0; i < 3; i++) begin
				p = $signed(r.vel[i]);
				if (p < 0) p = -p;
				p = ((p * dw) + (unit <<< (FB - 1))) >>> FB;
				if ($signed(r.vel[i]) < 0) p = -p;
				n = $signed(r.vec[i]);
				n = n + p;
				if (m_len == 0) begin
					res.w[3 + i] = clamp64(n);
				end else begin
					wt = {1'b0, m_len};
					rem = n % wt;
					if (rem < 0) rem = rem + wt;
					res.w[3 + i] = rem[63:0];
				end
			end
			res.w[6] = m_ctime;
			res.applied = 1'b1;
		end
		res.w[7] = grav_total;
		res.w[8] = drag_total;
		return res;
	endfunction

	// Record driver: holds a record until its transfer, then may idle.
	always @(posedge clk) begin : rec_driver
		bit go;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(predict_record(pending_recs.pop_front()));
				recs_sent++;
			end
			go = (s_tvalid && !s_tready)
				|| (pending_recs.size() > 0 && !(idle_en && $urandom_range(99) < 32));
			if (go) begin
				s_tdata <= {1'b0, pending_recs[0].active, pending_recs[0].tm, pending_recs[0].sd,
					pending_recs[0].vec, pending_recs[0].vel, pending_recs[0].mass};
				s_tuser <= pending_recs[0].req;
				s_tlast <= pending_recs[0].last;
			end
			s_tvalid <= go;
		end
	end

	// Result monitor with random stalls and one long hold-off.
	always @(posedge clk) begin : res_monitor
		res_t exp_r;
		bit rdy;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result transfer with nothing expected", $time);
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					for (int k = 0; k < 9; k++)
						if (m_tdata[64*k +: 64] !== exp_r.w[k]) begin
							$display("%0t: %s expected %h actual %h", $time, field_name[k],
								exp_r.w[k], m_tdata[64*k +: 64]);
							errors++;
						end
					if (m_tuser[0] !== exp_r.applied) begin
						$display("%0t: applied expected %b actual %b", $time,
							exp_r.applied, m_tuser[0]);
						errors++;
					end
					if (m_tlast !== exp_r.pass_end) begin
						$display("%0t: pass_end expected %b actual %b", $time,
							exp_r.pass_end, m_tlast);
						errors++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (!hold_done && recs_sent >= 150) begin
				hold_left = 400;
				hold_done = 1'b1;
				rdy = 1'b0;
			end else begin
				rdy = !(idle_en && $urandom_range(99) < 32);
			end
			m_tready <= rdy;
		end
	end

	// Write one register over the configuration channel.
	task automatic write_reg(plkd_pkg::cfg_reg_t r, logic [63:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_addr <= r;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (r)
			plkd_pkg::REG_INDIVIDUAL_STEPS: m_indiv = v[0];
			plkd_pkg::REG_SCALE_FACTOR:     m_scale = v[62:0];
			plkd_pkg::REG_HUBBLE_RATE:      m_hubble = v;
			plkd_pkg::REG_HALF_STEP_DT:     m_half = v[62:0];
			plkd_pkg::REG_CURRENT_TIME:     m_ctime = v;
			plkd_pkg::REG_DOMAIN_LENGTH:    m_len = v[62:0];
			plkd_pkg::REG_TIME_TOLERANCE:   m_tol = v[15:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_recs.size() > 0 || expected_results.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Random word: mostly moderate magnitudes, some full range, some extremes.
	function automatic logic [63:0] rnd_word();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(9))
			0: case ($urandom_range(4))
				0: r = 64'd0;
				1: r = 64'd1;
				2: r = '1;
				3: r = plkd_pkg::S64_MAX;
				default: r = plkd_pkg::S64_MIN;
			endcase
			1, 2: ;
			default: r = $signed(r) >>> $urandom_range(60, 14);
		endcase
		return r;
	endfunction

	function automatic rec_t mk_rec(logic [1:0] req, logic [62:0] mass, logic [63:0] v,
			logic [63:0] x, logic [62:0] sd, logic [63:0] tm, logic act, logic last);
		rec_t r;
		r.req = req;
		r.mass = mass;
		r.vel = {3{v}};
		r.vec = {x, -x, x};
		r.sd = sd;
		r.tm = tm;
		r.active = act;
		r.last = last;
		return r;
	endfunction

	// Random record; well-formed ones land in or just outside the time window, or mostly drift forward.
	task automatic add_random(bit wellformed);
		rec_t r;
		logic [63:0] t;
		int off;
		r.req = wellformed ? 2'($urandom_range(2)) : 2'($urandom_range(3));
		t = rnd_word();
		r.mass = t[62:0];
		for (int i = 0; i < 3; i++) begin
			r.vel[i] = rnd_word();
			r.vec[i] = rnd_word();
		end
		t = rnd_word();
		r.sd = wellformed ? 63'($urandom) << $urandom_range(12) : t[62:0];
		r.tm = rnd_word();
		r.active = 1'($urandom_range(1));
		r.last = ($urandom_range(15) == 0);
		if (wellformed) begin
			off = $urandom_range(0, 2 * m_tol + 2) - int'(m_tol) - 1;
			case (r.req)
				plkd_pkg::REQ_KICK_FIRST:
					r.tm = m_ctime - {m_half, 1'b0} + {1'b0, r.sd} + 64'(off);
				plkd_pkg::REQ_KICK_SECOND: r.tm = m_ctime + 64'(off);
				default: begin
					r.tm = m_ctime - 64'($urandom_range(3) == 0 ? off : $urandom);
					if (m_len != 0 && $urandom_range(1))
						for (int i = 0; i < 3; i++)
							r.vec[i] = {1'b0, m_len} - 64'($urandom_range(2)) - 64'd1;
				end
			endcase
		end
		pending_recs.push_back(r);
	endtask

	task automatic run_random(int count);
		repeat (count) add_random($urandom_range(99) < 80);
		drain();
	endtask

	initial begin
		m_indiv = 1'b0;
		m_scale = Q_ONE[62:0];
		m_hubble = '0;
		m_half = '0;
		m_ctime = '0;
		m_len = Q_ONE[62:0];
		m_tol = 16'd110;
		grav_total = '0;
		drag_total = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed records under reset settings, kicks gated on active.
		pending_recs.push_back(mk_rec(plkd_pkg::REQ_KICK_FIRST, '1, plkd_pkg::S64_MAX,
			plkd_pkg::S64_MAX, '1, '0, 1'b1, 1'b0));
		pending_recs.push_back(mk_rec(plkd_pkg::REQ_KICK_SECOND, '1, plkd_pkg::S64_MIN,
			plkd_pkg::S64_MIN, '1, '1, 1'b1, 1'b1));
		pending_recs.push_back(mk_rec(plkd_pkg::REQ_KICK_FIRST, Q_ONE[62:0], Q_ONE, Q_ONE,
			Q_ONE[62:0], '0, 1'b0, 1'b0));
		pending_recs.push_back(mk_rec(plkd_pkg::REQ_KICK_SECOND, '0, '0, '0, '0, '0,
			1'b1, 1'b0));
		pending_recs.push_back(mk_rec(REQ_NOP, '1, plkd_pkg::S64_MAX, plkd_pkg::S64_MIN,
			'1, '1, 1'b1, 1'b1));
		pending_recs.push_back(mk_rec(plkd_pkg::REQ_DRIFT, '0, -Q_ONE, 64'd5, '0, -Q_ONE,
			1'b0, 1'b0));
		pending_recs.push_back(mk_rec(plkd_pkg::REQ_DRIFT, '0, Q_ONE, Q_ONE, '0, '0,
			1'b0, 1'b0));
		pending_recs.push_back(mk_rec(plkd_pkg::REQ_DRIFT, '0, Q_ONE, Q_ONE, '0, 64'd1,
			1'b0, 1'b0));
		pending_recs.push_back(mk_rec(plkd_pkg::REQ_DRIFT, '0, plkd_pkg::S64_MAX,
			plkd_pkg::S64_MIN, '0, plkd_pkg::S64_MIN, 1'b1, 1'b1));
		pending_recs.push_back(mk_rec(plkd_pkg::REQ_DRIFT, '0, plkd_pkg::S64_MIN,
			plkd_pkg::S64_MAX, '1, 64'd1 + plkd_pkg::S64_MIN, 1'b0, 1'b0));
		pending_recs.push_back(mk_rec(plkd_pkg::REQ_KICK_SECOND, Q_ONE[62:0], 3 * Q_ONE,
			-Q_ONE, Q_ONE[62:0], '0, 1'b1, 1'b0));
		drain();

		// Windowed kicks with a mild Hubble drag in a wide box.
		write_reg(plkd_pkg::REG_INDIVIDUAL_STEPS, 64'd1);
		write_reg(plkd_pkg::REG_HUBBLE_RATE, Q_ONE >> 3);
		write_reg(plkd_pkg::REG_HALF_STEP_DT, 64'd123456789);
		write_reg(plkd_pkg::REG_CURRENT_TIME, 64'd98765432101);
		write_reg(plkd_pkg::REG_DOMAIN_LENGTH, Q_ONE * 100);
		pending_recs.push_back(mk_rec(plkd_pkg::REQ_KICK_SECOND, Q_ONE[62:0], Q_ONE, Q_ONE,
			Q_ONE[62:0], 64'd98765432101 + 64'd109, 1'b0, 1'b0));
		pending_recs.push_back(mk_rec(plkd_pkg::REQ_KICK_SECOND, Q_ONE[62:0], Q_ONE, Q_ONE,
			Q_ONE[62:0], 64'd98765432101 - 64'd110, 1'b0, 1'b0));
		run_random(250);

		// Extreme settings.
		write_reg(plkd_pkg::REG_INDIVIDUAL_STEPS, 64'd0);
		write_reg(plkd_pkg::REG_SCALE_FACTOR, plkd_pkg::S64_MAX);
		write_reg(plkd_pkg::REG_HUBBLE_RATE, plkd_pkg::S64_MAX);
		write_reg(plkd_pkg::REG_HALF_STEP_DT, plkd_pkg::S64_MAX);
		write_reg(plkd_pkg::REG_CURRENT_TIME, plkd_pkg::S64_MIN);
		write_reg(plkd_pkg::REG_DOMAIN_LENGTH, plkd_pkg::S64_MAX);
		write_reg(plkd_pkg::REG_TIME_TOLERANCE, 64'd65535);
		run_random(150);

		// Drag off by sign and scale, box of one LSB, tolerance zero.
		write_reg(plkd_pkg::REG_INDIVIDUAL_STEPS, 64'd1);
		write_reg(plkd_pkg::REG_SCALE_FACTOR, 64'd0);
		write_reg(plkd_pkg::REG_HUBBLE_RATE, plkd_pkg::S64_MIN);
		write_reg(plkd_pkg::REG_CURRENT_TIME, 64'd0);
		write_reg(plkd_pkg::REG_DOMAIN_LENGTH, 64'd1);
		write_reg(plkd_pkg::REG_TIME_TOLERANCE, 64'd0);
		run_random(150);

		// Unwrapped drift, tolerance one but kicks gated on active, no idling on either side.
		idle_en = 1'b0;
		write_reg(plkd_pkg::REG_INDIVIDUAL_STEPS, 64'd0);
		write_reg(plkd_pkg::REG_SCALE_FACTOR, Q_ONE);
		write_reg(plkd_pkg::REG_HUBBLE_RATE, Q_ONE >> 3);
		write_reg(plkd_pkg::REG_CURRENT_TIME, plkd_pkg::S64_MAX);
		write_reg(plkd_pkg::REG_DOMAIN_LENGTH, 64'd0);
		write_reg(plkd_pkg::REG_TIME_TOLERANCE, 64'd1);
		run_random(150);

		// Windowed kicks again with strong drag and a small box.
		idle_en = 1'b1;
		write_reg(plkd_pkg::REG_INDIVIDUAL_STEPS, 64'd1);
		write_reg(plkd_pkg::REG_HUBBLE_RATE, Q_ONE * 3);
		write_reg(plkd_pkg::REG_HALF_STEP_DT, Q_ONE >> 4);
		write_reg(plkd_pkg::REG_CURRENT_TIME, Q_ONE * 7);
		write_reg(plkd_pkg::REG_DOMAIN_LENGTH, Q_ONE * 3);
		write_reg(plkd_pkg::REG_TIME_TOLERANCE, 64'd200);
		run_random(200);

		repeat (150) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

@@ particle_leapfrog_kick_drift_top.f @@
hw/rtl/plkd_pkg.sv
hw/rtl/plkd_mul.sv
hw/rtl/plkd_div.sv
hw/rtl/particle_leapfrog_kick_drift_top.sv
bench/tb_particle_leapfrog_kick_drift_top.sv
